[rtl/core/ts_video_access_unit_extractor_top_macros.svh]
`ifndef TS_VIDEO_ACCESS_UNIT_EXTRACTOR_TOP_MACROS_SVH
`define TS_VIDEO_ACCESS_UNIT_EXTRACTOR_TOP_MACROS_SVH

// check that an antecedent implies a consequent in the same cycle
`define TVAE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tvae check failed");

// check that an antecedent implies a consequent in the next cycle
`define TVAE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tvae check failed");

`endif

[rtl/core/ts_vae_pkg.sv]
`default_nettype none
package ts_vae_pkg;

    localparam int OFFSET_WIDTH_DEF      = 48;
    localparam int ERROR_COUNT_WIDTH_DEF = 16;

    localparam logic [7:0] PKT_LAST   = 8'd187;
    localparam logic [8:0] PKT_LEN    = 9'd188;
    localparam logic [7:0] SYNC_BYTE  = 8'h47;
    localparam logic [4:0] CAP_DEPTH  = 5'd19;
    localparam logic [1:0] AFC_PAYLOAD = 2'd1;
    localparam logic [1:0] AFC_BOTH    = 2'd3;
    localparam logic [1:0] FLAGS_PTS   = 2'd2;
    localparam logic [1:0] FLAGS_BOTH  = 2'd3;
    localparam logic [3:0] VIDEO_SID_HI = 4'hE;

    localparam int Q_DEPTH = 4;

    typedef struct packed {
        logic [31:0] unit_number;
        logic [32:0] pts_value;
        logic        pts_present;
        logic [32:0] dts_value;
        logic        dts_present;
        logic [63:0] unit_base;
        logic [63:0] es_end;
        logic [31:0] err_tally;
        logic        last_of_run;
    } t_unit_rec;

    typedef struct packed {
        logic we0;
        logic we1;
    } t_q_wr;

    typedef struct packed {
        logic [$clog2(Q_DEPTH+1)-1:0] count;
    } t_q_stat;

    function automatic logic [32:0] stamp(input logic [7:0] p0, input logic [7:0] p1,
                                          input logic [7:0] p2, input logic [7:0] p3,
                                          input logic [7:0] p4);
        stamp = {p0[3:1], p1, p2[7:1], p3, p4[7:1]};
    endfunction

endpackage
`default_nettype wire

[rtl/core/ts_vae_front.sv]
`default_nettype none
module ts_vae_front #(
    parameter int OFFSET_WIDTH      = ts_vae_pkg::OFFSET_WIDTH_DEF,
    parameter int ERROR_COUNT_WIDTH = ts_vae_pkg::ERROR_COUNT_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_accept,
    input  wire logic [7:0]             i_data_byte,
    input  wire logic                   i_end_of_stream,
    input  wire logic [12:0]            i_video_pid,
    output ts_vae_pkg::t_unit_rec       o_rec0,
    output ts_vae_pkg::t_unit_rec       o_rec1,
    output ts_vae_pkg::t_q_wr           o_wr
);
    import ts_vae_pkg::*;

    localparam int OW = OFFSET_WIDTH;
    localparam int EW = ERROR_COUNT_WIDTH;

    logic [7:0]    r_pos;
    logic [7:0]    r_hb [5];
    logic [7:0]    r_cap [19];
    logic [3:0]    r_prev_cc;
    logic          r_prev_v;
    logic          r_open;
    logic [OW-1:0] r_running;
    logic [32:0]   r_pts;
    logic          r_pts_p;
    logic [32:0]   r_dts;
    logic          r_dts_p;
    logic [OW-1:0] r_offset;
    logic [EW-1:0] r_errors;
    logic [31:0]   r_counter;

    logic [7:0]    n_pos;
    logic [3:0]    n_prev_cc;
    logic          n_prev_v;
    logic          n_open;
    logic [OW-1:0] n_running;
    logic [32:0]   n_pts;
    logic          n_pts_p;
    logic [32:0]   n_dts;
    logic          n_dts_p;
    logic [OW-1:0] n_offset;
    logic [EW-1:0] n_errors;
    logic [31:0]   n_counter;

    logic [7:0]  hb4;
    logic [8:0]  h_sum;
    logic [7:0]  hlen;
    logic [7:0]  cap_rel;
    logic        cap_we;
    logic [4:0]  cap_idx;
    logic [7:0]  cap_e [19];
    logic        commit;
    logic        match;
    logic        cc_err;
    logic [EW-1:0] errors1;
    logic        payload;
    logic        start;
    logic        emit0;
    logic        emit_e;
    logic [7:0]  plen;
    logic        pes_ok;
    logic [1:0]  flags;
    logic [8:0]  skip;
    logic [7:0]  add;
    logic [OW:0] sum;
    t_unit_rec   rec_s;
    t_unit_rec   rec_e;

    always_comb begin
        hb4     = (r_pos == 8'd4) ? i_data_byte : r_hb[4];
        h_sum   = 9'd5 + {1'b0, hb4};
        unique case (r_hb[3][5:4])
            AFC_PAYLOAD: hlen = 8'd4;
            AFC_BOTH:    hlen = (h_sum < PKT_LEN) ? h_sum[7:0] : 8'd0;
            default:     hlen = 8'd0;
        endcase
        cap_rel = r_pos - hlen;
        cap_we  = (r_pos >= 8'd4) && (hlen != 8'd0) && (r_pos >= hlen)
                  && (cap_rel < {3'd0, CAP_DEPTH});
        cap_idx = cap_rel[4:0];
        for (int i = 0; i < 19; i++) begin
            cap_e[i] = (cap_we && cap_idx == 5'(i)) ? i_data_byte : r_cap[i];
        end

        commit  = (r_pos == PKT_LAST);
        match   = commit && (r_hb[0] == SYNC_BYTE) && ({r_hb[1][4:0], r_hb[2]} == i_video_pid);
        cc_err  = r_prev_v && (r_hb[3][3:0] != (r_prev_cc + 4'd1)) && r_open;
        errors1 = (match && cc_err && r_errors != '1) ? r_errors + EW'(1) : r_errors;
        payload = match && (r_hb[3][7:6] == 2'd0) && (hlen != 8'd0);
        start   = payload && r_hb[1][6];
        emit0   = start && r_open;
        plen    = 8'(PKT_LEN - {1'b0, hlen});

        pes_ok  = (plen >= 8'd9) && (cap_e[0] == 8'd0) && (cap_e[1] == 8'd0)
                  && (cap_e[2] == 8'd1) && (cap_e[3][7:4] == VIDEO_SID_HI);
        flags   = cap_e[7][7:6];
        skip    = pes_ok ? 9'd9 + {1'b0, cap_e[8]} : 9'd0;

        rec_s.unit_number = r_counter;
        rec_s.pts_value   = r_pts;
        rec_s.pts_present = r_pts_p;
        rec_s.dts_value   = r_dts;
        rec_s.dts_present = r_dts_p;
        rec_s.unit_base   = 64'(r_offset);
        rec_s.es_end      = 64'(r_running);
        rec_s.err_tally   = 32'(errors1);
        rec_s.last_of_run = 1'b0;

        n_prev_cc = match ? r_hb[3][3:0] : r_prev_cc;
        n_prev_v  = r_prev_v || match;
        n_open    = r_open;
        n_pts     = r_pts;
        n_pts_p   = r_pts_p;
        n_dts     = r_dts;
        n_dts_p   = r_dts_p;
        n_offset  = r_offset;
        n_errors  = errors1;
        n_counter = r_counter;
        add       = 8'd0;
        if (start) begin
            if (emit0 && r_counter != '1) begin
                n_counter = r_counter + 32'd1;
            end
            n_pts_p  = pes_ok && ((flags == FLAGS_PTS && plen >= 8'd14)
                                  || (flags == FLAGS_BOTH && plen >= 8'd19));
            n_dts_p  = pes_ok && flags == FLAGS_BOTH && plen >= 8'd19;
            n_pts    = n_pts_p ? stamp(cap_e[9], cap_e[10], cap_e[11], cap_e[12], cap_e[13])
                               : 33'd0;
            n_dts    = n_dts_p ? stamp(cap_e[14], cap_e[15], cap_e[16], cap_e[17], cap_e[18])
                               : 33'd0;
            n_offset = r_running;
            n_errors = '0;
            n_open   = 1'b1;
            add      = ({1'b0, plen} > skip) ? 8'({1'b0, plen} - skip) : 8'd0;
        end else if (payload && r_open) begin
            add = plen;
        end
        sum       = {1'b0, r_running} + (OW+1)'(add);
        n_running = sum[OW] ? '1 : sum[OW-1:0];
        n_pos     = commit ? 8'd0 : r_pos + 8'd1;

        emit_e            = i_end_of_stream && n_open;
        rec_e.unit_number = n_counter;
        rec_e.pts_value   = n_pts;
        rec_e.pts_present = n_pts_p;
        rec_e.dts_value   = n_dts;
        rec_e.dts_present = n_dts_p;
        rec_e.unit_base   = 64'(n_offset);
        rec_e.es_end      = 64'(n_running);
        rec_e.err_tally   = 32'(n_errors);
        rec_e.last_of_run = 1'b1;

        o_rec0             = emit0 ? rec_s : rec_e;
        o_rec0.last_of_run = !(emit0 && emit_e);
        o_rec1             = rec_e;
        o_wr.we0           = i_accept && (emit0 || emit_e);
        o_wr.we1           = i_accept && emit0 && emit_e;
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            if (r_pos < 8'd5) begin
                r_hb[r_pos[2:0]] <= i_data_byte;
            end
            if (cap_we) begin
                r_cap[cap_idx] <= i_data_byte;
            end
        end
        if (!i_rst_n || (i_accept && i_end_of_stream)) begin
            r_pos     <= '0;
            r_prev_cc <= '0;
            r_prev_v  <= 1'b0;
            r_open    <= 1'b0;
            r_running <= '0;
            r_pts     <= '0;
            r_pts_p   <= 1'b0;
            r_dts     <= '0;
            r_dts_p   <= 1'b0;
            r_offset  <= '0;
            r_errors  <= '0;
            r_counter <= '0;
        end else if (i_accept) begin
            r_pos     <= n_pos;
            r_prev_cc <= n_prev_cc;
            r_prev_v  <= n_prev_v;
            r_open    <= n_open;
            r_running <= n_running;
            r_pts     <= n_pts;
            r_pts_p   <= n_pts_p;
            r_dts     <= n_dts;
            r_dts_p   <= n_dts_p;
            r_offset  <= n_offset;
            r_errors  <= n_errors;
            r_counter <= n_counter;
        end
    end

endmodule
`default_nettype wire

[rtl/core/ts_vae_queue.sv]
`default_nettype none
module ts_vae_queue (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire ts_vae_pkg::t_q_wr      i_wr,
    input  wire ts_vae_pkg::t_unit_rec  i_rec0,
    input  wire ts_vae_pkg::t_unit_rec  i_rec1,
    input  wire logic                   i_pop,
    output ts_vae_pkg::t_unit_rec       o_head,
    output ts_vae_pkg::t_q_stat         o_stat
);
    import ts_vae_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_unit_rec   r_mem [Q_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_count;
    logic [PW-1:0] wp1;
    logic [CW-1:0] n_count;

    always_comb begin
        wp1     = r_wp + PW'(1);
        n_count = r_count + CW'(i_wr.we0) + CW'(i_wr.we1) - CW'(i_pop);
        o_head  = r_mem[r_rp];
        o_stat.count = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we0) begin
            r_mem[r_wp] <= i_rec0;
        end
        if (i_wr.we1) begin
            r_mem[wp1] <= i_rec1;
        end
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + PW'(i_wr.we0) + PW'(i_wr.we1);
            r_rp    <= r_rp + PW'(i_pop);
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

[rtl/core/ts_vae_back.sv]
`default_nettype none
module ts_vae_back #(
    parameter int OFFSET_WIDTH      = ts_vae_pkg::OFFSET_WIDTH_DEF,
    parameter int ERROR_COUNT_WIDTH = ts_vae_pkg::ERROR_COUNT_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire ts_vae_pkg::t_unit_rec        i_head,
    input  wire ts_vae_pkg::t_q_stat          i_stat,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [31:0]                       o_unit_number,
    output logic [32:0]                       o_pts_value,
    output logic                              o_pts_present,
    output logic [32:0]                       o_dts_value,
    output logic                              o_dts_present,
    output logic [OFFSET_WIDTH-1:0]           o_es_offset,
    output logic [OFFSET_WIDTH-1:0]           o_es_size,
    output logic [ERROR_COUNT_WIDTH-1:0]      o_cc_error_count,
    output logic                              o_last_of_run
);
    import ts_vae_pkg::*;

    logic        r_valid;
    logic [63:0] size;

    always_comb begin
        o_pop   = (i_stat.count != '0) && (!r_valid || i_ready);
        size    = (i_head.es_end >= i_head.unit_base) ? i_head.es_end - i_head.unit_base
                                                      : 64'd0;
        o_valid = r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_unit_number    <= i_head.unit_number;
            o_pts_value      <= i_head.pts_value;
            o_pts_present    <= i_head.pts_present;
            o_dts_value      <= i_head.dts_value;
            o_dts_present    <= i_head.dts_present;
            o_es_offset      <= i_head.unit_base[OFFSET_WIDTH-1:0];
            o_es_size        <= size[OFFSET_WIDTH-1:0];
            o_cc_error_count <= i_head.err_tally[ERROR_COUNT_WIDTH-1:0];
            o_last_of_run    <= i_head.last_of_run;
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule
`default_nettype wire

[rtl/core/ts_video_access_unit_extractor_top.sv]
// channel  | direction | handshake                  | payload
// input    | in        | i_valid / o_ready          | i_data_byte, i_end_of_stream
// config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_video_pid
// result   | out       | o_valid / i_ready          | o_unit_number .. o_last_of_run
//
// One byte per cycle is taken unless stalled; results are queued, then registered.
// A packet's last byte or an end-of-stream byte may queue up to two results.
// The input stalls when the four-entry result queue has fewer than two free slots.
// Synchronous active-low reset clears all stream state and the video PID.
// No clearing pass; configuration is always ready.
`default_nettype none
module ts_video_access_unit_extractor_top #(
    parameter int OFFSET_WIDTH      = ts_vae_pkg::OFFSET_WIDTH_DEF,
    parameter int ERROR_COUNT_WIDTH = ts_vae_pkg::ERROR_COUNT_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [7:0]                   i_data_byte,
    input  wire logic                         i_end_of_stream,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [12:0]                  i_cfg_video_pid,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [31:0]                       o_unit_number,
    output logic [32:0]                       o_pts_value,
    output logic                              o_pts_present,
    output logic [32:0]                       o_dts_value,
    output logic                              o_dts_present,
    output logic [OFFSET_WIDTH-1:0]           o_es_offset,
    output logic [OFFSET_WIDTH-1:0]           o_es_size,
    output logic [ERROR_COUNT_WIDTH-1:0]      o_cc_error_count,
    output logic                              o_last_of_run
);
    import ts_vae_pkg::*;

`include "ts_video_access_unit_extractor_top_macros.svh"

    logic [12:0] r_video_pid;
    logic        accept;
    t_unit_rec   rec0;
    t_unit_rec   rec1;
    t_unit_rec   head;
    t_q_wr       wr;
    t_q_stat     stat;
    logic        pop;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (stat.count <= ($clog2(Q_DEPTH+1))'(Q_DEPTH - 2));
    assign accept      = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_pid <= '0;
        end else if (i_cfg_valid) begin
            r_video_pid <= i_cfg_video_pid;
        end
    end

    ts_vae_front #(
        .OFFSET_WIDTH      (OFFSET_WIDTH),
        .ERROR_COUNT_WIDTH (ERROR_COUNT_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .i_video_pid     (r_video_pid),
        .o_rec0          (rec0),
        .o_rec1          (rec1),
        .o_wr            (wr)
    );

    ts_vae_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_rec0  (rec0),
        .i_rec1  (rec1),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (stat)
    );

    ts_vae_back #(
        .OFFSET_WIDTH      (OFFSET_WIDTH),
        .ERROR_COUNT_WIDTH (ERROR_COUNT_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head),
        .i_stat           (stat),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_unit_number    (o_unit_number),
        .o_pts_value      (o_pts_value),
        .o_pts_present    (o_pts_present),
        .o_dts_value      (o_dts_value),
        .o_dts_present    (o_dts_present),
        .o_es_offset      (o_es_offset),
        .o_es_size        (o_es_size),
        .o_cc_error_count (o_cc_error_count),
        .o_last_of_run    (o_last_of_run)
    );

    `TVAE_ASSERT_IMP(a_q_bound, i_clk, i_rst_n, 1'b1, stat.count <= ($clog2(Q_DEPTH+1))'(Q_DEPTH))
    `TVAE_ASSERT_IMP(a_pts_zero, i_clk, i_rst_n, o_valid && !o_pts_present, o_pts_value == 33'd0)
    `TVAE_ASSERT_IMP(a_dts_zero, i_clk, i_rst_n, o_valid && !o_dts_present, o_dts_value == 33'd0)
    `TVAE_ASSERT_NXT(a_pop_fill, i_clk, i_rst_n, pop, o_valid)

endmodule
`default_nettype wire
